@@ src/rgc_pkg.sv @@
// ----------------------------------------------------------------------------
// rgc_pkg
// Types and constants shared by the range group classifier modules.
// ----------------------------------------------------------------------------
`default_nettype none

package rgc_pkg;

	localparam int unsigned SLOT_W  = 6;
	localparam int unsigned CLASS_W = 2;
	localparam int unsigned WORD_W  = 64;
	localparam int unsigned BOUND_W = 2 * WORD_W;

	// Slots that a load can address at all.
	localparam int unsigned SLOT_RANGE = 2 ** SLOT_W;

	// Stream payload widths.
	localparam int unsigned S_DATA_W = 264;
	localparam int unsigned M_DATA_W = 8;

	localparam logic KIND_LOAD  = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	localparam logic [CLASS_W-1:0] CLASS_EMPTY  = 2'd0;
	localparam logic [CLASS_W-1:0] CLASS_NUMBER = 2'd1;
	localparam logic [CLASS_W-1:0] CLASS_IPV4   = 2'd2;
	localparam logic [CLASS_W-1:0] CLASS_IPV6   = 2'd3;

	typedef struct packed {
		logic [BOUND_W-1:0] lo;
		logic [BOUND_W-1:0] hi;
	} rgc_bounds_t;

	// One table entry as returned by a read.
	typedef struct packed {
		logic               valid;
		logic [CLASS_W-1:0] cls;
		rgc_bounds_t        bounds;
	} rgc_entry_t;

endpackage

`default_nettype wire

@@ src/rgc_table.sv @@
// ----------------------------------------------------------------------------
// rgc_table
// Range table: class and bound memories with one write and one registered
// read port, plus per-slot valid flags that reset clears.
// ----------------------------------------------------------------------------
`default_nettype none

module rgc_table
	import rgc_pkg::*;
#(
	parameter int unsigned DEPTH = 64,
	parameter int unsigned IW    = 6
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              we,
	input  wire logic [IW-1:0]     waddr,
	input  wire logic [CLASS_W-1:0] wcls,
	input  wire rgc_bounds_t       wbounds,
	input  wire logic [IW-1:0]     raddr,
	output rgc_entry_t             rdata
);

	logic [CLASS_W-1:0] class_mem [DEPTH];
	rgc_bounds_t        bound_mem [DEPTH];
	logic [DEPTH-1:0]   valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (we) begin
			valid_q[waddr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			class_mem[waddr] <= wcls;
			bound_mem[waddr] <= wbounds;
		end
		rdata.valid  <= valid_q[raddr];
		rdata.cls    <= class_mem[raddr];
		rdata.bounds <= bound_mem[raddr];
	end

endmodule

`default_nettype wire

@@ src/rgc_range_cmp.sv @@
// ----------------------------------------------------------------------------
// rgc_range_cmp
// Containment test: entry low <= query low and query high <= entry high,
// as unsigned 128-bit values, or on the lower words only for numbers.
// ----------------------------------------------------------------------------
`default_nettype none

module rgc_range_cmp
	import rgc_pkg::*;
(
	input  wire logic        number,
	input  wire rgc_bounds_t entry,
	input  wire rgc_bounds_t query,
	output logic             ok
);

	logic [BOUND_W-1:0] mask;

	// Numbers carry no meaning in the upper words, so they are masked off.
	assign mask = number ? {{WORD_W{1'b0}}, {WORD_W{1'b1}}} : {BOUND_W{1'b1}};

	assign ok = ((entry.lo & mask) <= (query.lo & mask)) &&
		((query.hi & mask) <= (entry.hi & mask));

endmodule

`default_nettype wire

@@ src/range_group_classifier.sv @@
// ----------------------------------------------------------------------------
// range_group_classifier
// First-match range lookup. Loads write a table slot; a query scans the
// slots upward from slot 1 and reports the first one that holds the query.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  tdata                                   tuser
//  s_*       in         slot, range_class, low_upper, low_lower, kind
//                       high_upper, high_lower
//  m_*       out        match_slot                              hit
//
// A load writes its slot as it is taken. A query of the empty class goes
// straight to the output without a scan; any other query reads one slot per
// cycle through the table's read port and one shared range comparator,
// ending early at the first match. Reset clears the valid flags of all slots
// at once. A result waiting in the output register does not hold off new
// transactions until the next result is ready to move into it.
// ----------------------------------------------------------------------------
`default_nettype none

module range_group_classifier
	import rgc_pkg::*;
#(
	parameter int unsigned ENTRIES = 64
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	// slot[5:0], range_class[7:6], low_upper[71:8], low_lower[135:72],
	// high_upper[199:136], high_lower[263:200]
	input  wire logic [S_DATA_W-1:0] s_tdata,
	// kind[0]
	input  wire logic                s_tuser,
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	// match_slot[5:0], zero[7:6]
	output logic [M_DATA_W-1:0]      m_tdata,
	// hit[0]
	output logic                     m_tuser,
	output logic                     m_tvalid,
	input  wire logic                m_tready
);

	// Only slots a load can address need storage; the rest stay empty.
	localparam int unsigned STORE = (ENTRIES < SLOT_RANGE) ? ENTRIES : SLOT_RANGE;
	localparam int unsigned IW    = $clog2(STORE);
	localparam logic [IW-1:0] LAST = IW'(STORE - 1);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_EMIT = 3'b100
	} state_t;

	state_t             state_q;
	logic [IW-1:0]      idx_q;
	logic [IW-1:0]      cmp_idx_q;
	logic               pend_q;
	logic [CLASS_W-1:0] q_cls_q;
	rgc_bounds_t        q_bounds_q;
	logic               res_hit_q;
	logic [SLOT_W-1:0]  res_slot_q;
	logic               m_valid_q;
	logic               m_hit_q;
	logic [SLOT_W-1:0]  m_slot_q;

	logic [SLOT_W-1:0]  in_slot;
	logic [CLASS_W-1:0] in_cls;
	rgc_bounds_t        in_bounds;
	logic               in_take;
	logic               tbl_we;
	rgc_entry_t         rd_entry;
	logic               range_ok;
	logic               match;

	assign in_slot   = s_tdata[5:0];
	assign in_cls    = s_tdata[7:6];
	assign in_bounds = {s_tdata[71:8], s_tdata[135:72], s_tdata[199:136], s_tdata[263:200]};

	assign s_tready = (state_q == ST_IDLE);
	assign in_take  = s_tvalid && s_tready;
	assign tbl_we   = in_take && (s_tuser == KIND_LOAD) && (32'(in_slot) < ENTRIES);

	rgc_table #(
		.DEPTH (STORE),
		.IW    (IW)
	) u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.we      (tbl_we),
		.waddr   (in_slot[IW-1:0]),
		.wcls    (in_cls),
		.wbounds (in_bounds),
		.raddr   (idx_q),
		.rdata   (rd_entry)
	);

	rgc_range_cmp u_cmp (
		.number (q_cls_q == CLASS_NUMBER),
		.entry  (rd_entry.bounds),
		.query  (q_bounds_q),
		.ok     (range_ok)
	);

	assign match = rd_entry.valid && (rd_entry.cls == q_cls_q) && range_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			idx_q     <= '0;
			cmp_idx_q <= '0;
			pend_q    <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			if ((state_q == ST_EMIT) && (!m_valid_q || m_tready)) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_take && (s_tuser == KIND_QUERY)) begin
						idx_q  <= IW'(1);
						pend_q <= 1'b0;
						if (in_cls == CLASS_EMPTY) begin
							state_q <= ST_EMIT;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (pend_q && (match || (cmp_idx_q == LAST))) begin
						pend_q  <= 1'b0;
						state_q <= ST_EMIT;
					end else begin
						pend_q    <= 1'b1;
						cmp_idx_q <= idx_q;
						if (idx_q != LAST) begin
							idx_q <= idx_q + IW'(1);
						end
					end
				end
				ST_EMIT: begin
					if (!m_valid_q || m_tready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Query capture, scan result and output payload.
	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && in_take && (s_tuser == KIND_QUERY)) begin
			q_cls_q    <= in_cls;
			q_bounds_q <= in_bounds;
			res_hit_q  <= 1'b0;
			res_slot_q <= '0;
		end
		if ((state_q == ST_SCAN) && pend_q && match) begin
			res_hit_q  <= 1'b1;
			res_slot_q <= SLOT_W'(cmp_idx_q);
		end
		if ((state_q == ST_EMIT) && (!m_valid_q || m_tready)) begin
			m_hit_q  <= res_hit_q;
			m_slot_q <= res_slot_q;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = m_hit_q;
	assign m_tdata  = {{(M_DATA_W - SLOT_W){1'b0}}, m_slot_q};

endmodule

`default_nettype wire

@@ tb/range_group_classifier_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// range_group_classifier_tb
// Self-checking testbench for the first-match range lookup. A short table of
// directed transactions covers empty tables, slot zero, the empty class,
// number-class word masking, inverted ranges and full-width bounds. A long
// random stream of loads and queries follows, mostly queries cut from ranges
// already in the table. Every result is checked against its typed row or a
// local model of the slot table while both stream sides stall at random.
// ----------------------------------------------------------------------------

module range_group_classifier_tb;
	import rgc_pkg::*;

	localparam int ENTRIES      = 64;
	localparam int RANDOM_ITEMS = 625;
	localparam int HOLD_CYCLES  = 600;
	localparam int HOLD_AFTER   = 120;
	localparam int DRAIN_CYCLES = 80;
	localparam bit TYPED        = 1'b1;
	localparam bit PREDICTED    = 1'b0;
	localparam logic [63:0]  W1   = {64{1'b1}};
	localparam logic [127:0] ALL1 = {128{1'b1}};
	localparam logic [127:0] ZERO = {128{1'b0}};

	typedef struct packed {
		logic               hit;
		logic [SLOT_W-1:0]  slot;
	} lookup_t;

	typedef struct {
		logic               kind;
		logic [SLOT_W-1:0]  slot;
		logic [CLASS_W-1:0] cls;
		logic [BOUND_W-1:0] lo;
		logic [BOUND_W-1:0] hi;
		bit                 typed;
		lookup_t            typed_result;
	} stim_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic [S_DATA_W-1:0] s_tdata;
	logic                s_tuser;
	logic                s_tvalid;
	logic                s_tready;
	logic [M_DATA_W-1:0] m_tdata;
	logic                m_tuser;
	logic                m_tvalid;
	logic                m_tready;

	// Local copy of the slot table.
	logic [CLASS_W-1:0] holder_cls [ENTRIES];
	logic [BOUND_W-1:0] holder_lo  [ENTRIES];
	logic [BOUND_W-1:0] holder_hi  [ENTRIES];

	lookup_t pending_results[$];
	lookup_t oldest;
	stim_t   directed[$];

	int  errors       = 0;
	int  results_seen = 0;
	int  loads_sent   = 0;
	int  queries_sent = 0;
	int  hits_seen    = 0;
	bit  steady       = 1'b0;
	bit  held         = 1'b0;

	range_group_classifier #(.ENTRIES(ENTRIES)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		#4_000_000;
		$display("Timed out with %0d results outstanding.", pending_results.size());
		$display("FAIL");
		$finish;
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		errors++;
		$display("ERROR at %0t: %s: got %0d, expected %0d", $realtime, what, got, want);
	endtask

	// Mostly short gaps, a few long ones, none during the steady stretch.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 65)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Word values biased toward the corners so upper words often tie.
	function automatic logic [63:0] rand_word();
		case ($urandom_range(0, 5))
			0: return 64'd0;
			1: return W1;
			2: return 64'($urandom_range(0, 255));
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic lookup_t find_first_holder(input logic [CLASS_W-1:0] cls,
			input logic [BOUND_W-1:0] lo, input logic [BOUND_W-1:0] hi);
		lookup_t r;
		bit      ok;
		r = '0;
		if (cls == CLASS_EMPTY)
			return r;
		for (int s = 1; s < ENTRIES; s++) begin
			if (holder_cls[s] != cls)
				continue;
			if (cls == CLASS_NUMBER)
				ok = holder_lo[s][63:0] <= lo[63:0] && hi[63:0] <= holder_hi[s][63:0];
			else
				ok = holder_lo[s] <= lo && hi <= holder_hi[s];
			if (ok) begin
				r.hit  = 1'b1;
				r.slot = SLOT_W'(s);
				return r;
			end
		end
		return r;
	endfunction

	function automatic stim_t row(input logic kind, input logic [SLOT_W-1:0] slot,
			input logic [CLASS_W-1:0] cls, input logic [BOUND_W-1:0] lo,
			input logic [BOUND_W-1:0] hi, input bit typed, input logic hit,
			input logic [SLOT_W-1:0] match_slot);
		stim_t it;
		it.kind         = kind;
		it.slot         = slot;
		it.cls          = cls;
		it.lo           = lo;
		it.hi           = hi;
		it.typed        = typed;
		it.typed_result = {hit, match_slot};
		return it;
	endfunction

	task automatic make_random_item(output stim_t it);
		int used[$];
		int r;
		int s;
		r = $urandom_range(0, 99);
		for (int i = 1; i < ENTRIES; i++)
			if (holder_cls[i] != CLASS_EMPTY)
				used.push_back(i);
		it = row(KIND_QUERY, 6'($urandom_range(0, 63)), 2'($urandom_range(0, 3)),
			{rand_word(), rand_word()}, {rand_word(), rand_word()}, PREDICTED, 1'b0, 6'd0);
		if (r < 30) begin
			it.kind = KIND_LOAD;
			it.cls  = ($urandom_range(0, 7) == 0) ? CLASS_EMPTY : 2'($urandom_range(1, 3));
			if ($urandom_range(0, 4) != 0)
				it.hi = it.lo + {64'($urandom_range(0, 1)), rand_word()};
		end else if (r < 85 && used.size() > 0) begin
			// Cut the query from a stored range, sometimes just past its edges.
			s     = used[$urandom_range(0, used.size() - 1)];
			it.cls = holder_cls[s];
			it.lo = holder_lo[s] + 128'($urandom_range(0, 3));
			it.hi = holder_hi[s] - 128'($urandom_range(0, 3));
			if ($urandom_range(0, 4) == 0) begin
				if ($urandom_range(0, 1))
					it.lo = holder_lo[s] - 128'd1;
				else
					it.hi = holder_hi[s] + 128'd1;
			end
			if (it.cls == CLASS_NUMBER) begin
				it.lo[127:64] = rand_word();
				it.hi[127:64] = rand_word();
			end
			if ($urandom_range(0, 9) == 0)
				it.cls = 2'($urandom_range(0, 3));
		end
	endtask

	task automatic drive_item(input stim_t it);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= it.kind;
		s_tdata  <= {it.hi[63:0], it.hi[127:64], it.lo[63:0], it.lo[127:64], it.cls, it.slot};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		if (it.kind == KIND_LOAD) begin
			loads_sent++;
			holder_cls[it.slot] = it.cls;
			holder_lo[it.slot]  = it.lo;
			holder_hi[it.slot]  = it.hi;
		end else begin
			queries_sent++;
			pending_results.push_back(it.typed ? it.typed_result
				: find_first_holder(it.cls, it.lo, it.hi));
		end
		@(negedge clk);
	endtask

	// Receiver: random stalls, plus one long hold-off so the block backs up.
	initial begin
		m_tready = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (!held && results_seen >= HOLD_AFTER) begin
				held = 1'b1;
				m_tready <= 1'b0;
				for (int n = 0; n < HOLD_CYCLES; n++)
					@(negedge clk);
			end else if (pick_gap() > 0) begin
				m_tready <= 1'b0;
				repeat (pick_gap() + 1) @(negedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			hits_seen += int'(m_tuser);
			if (pending_results.size() == 0) begin
				report_mismatch("result with no query outstanding", int'(m_tdata), 0);
			end else begin
				oldest = pending_results.pop_front();
				if (m_tuser !== oldest.hit)
					report_mismatch("hit", int'(m_tuser), int'(oldest.hit));
				if (m_tdata[SLOT_W-1:0] !== oldest.slot)
					report_mismatch("match_slot", int'(m_tdata[SLOT_W-1:0]),
						int'(oldest.slot));
				if (m_tdata[M_DATA_W-1:SLOT_W] !== '0)
					report_mismatch("tdata padding", int'(m_tdata[M_DATA_W-1:SLOT_W]), 0);
			end
		end
	end

	initial begin
		stim_t it;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tuser  = KIND_LOAD;
		s_tdata  = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			holder_cls[i] = CLASS_EMPTY;
			holder_lo[i]  = '0;
			holder_hi[i]  = '0;
		end

		// Query kind rows with TYPED carry an expectation that is plain to see.
		directed.push_back(row(KIND_QUERY, 6'd9, CLASS_NUMBER, ZERO, ALL1, TYPED, 1'b0, 6'd0));
		directed.push_back(row(KIND_QUERY, 6'd63, CLASS_IPV6, ZERO, ALL1, TYPED, 1'b0, 6'd0));
		directed.push_back(row(KIND_LOAD, 6'd0, CLASS_NUMBER, ZERO, ALL1, PREDICTED,
			1'b0, 6'd0));
		directed.push_back(row(KIND_QUERY, 6'd0, CLASS_NUMBER, 128'd5, 128'd5, TYPED,
			1'b0, 6'd0));
		directed.push_back(row(KIND_LOAD, 6'd63, CLASS_IPV6, ZERO, ALL1, PREDICTED,
			1'b0, 6'd0));
		directed.push_back(row(KIND_QUERY, 6'd0, CLASS_IPV6, ALL1, ALL1, TYPED, 1'b1, 6'd63));
		directed.push_back(row(KIND_QUERY, 6'd0, CLASS_IPV6, ZERO, ZERO, TYPED, 1'b1, 6'd63));
		directed.push_back(row(KIND_LOAD, 6'd1, CLASS_EMPTY, ZERO, ALL1, PREDICTED,
			1'b0, 6'd0));
		directed.push_back(row(KIND_QUERY, 6'd1, CLASS_EMPTY, ZERO, ALL1, TYPED, 1'b0, 6'd0));
		// Number class: upper words are don't-care on both sides.
		directed.push_back(row(KIND_LOAD, 6'd2, CLASS_NUMBER, {W1, 64'd10}, {64'd0, 64'd20},
			PREDICTED, 1'b0, 6'd0));
		directed.push_back(row(KIND_QUERY, 6'd0, CLASS_NUMBER, {64'd0, 64'd12}, {W1, 64'd15},
			TYPED, 1'b1, 6'd2));
		directed.push_back(row(KIND_QUERY, 6'd0, CLASS_NUMBER, 128'd5, 128'd15, PREDICTED,
			1'b0, 6'd0));
		directed.push_back(row(KIND_LOAD, 6'd3, CLASS_IPV4, 128'h0A00_0000, 128'h0AFF_FFFF,
			PREDICTED, 1'b0, 6'd0));
		directed.push_back(row(KIND_QUERY, 6'd0, CLASS_IPV4, 128'h0A01_0203, 128'h0A01_0203,
			PREDICTED, 1'b0, 6'd0));
		// Inverted ranges go through the same containment test.
		directed.push_back(row(KIND_QUERY, 6'd0, CLASS_IPV4, 128'h0A00_00FF, 128'h0A00_0001,
			PREDICTED, 1'b0, 6'd0));
		directed.push_back(row(KIND_LOAD, 6'd4, CLASS_IPV4, 128'd20, 128'd10, PREDICTED,
			1'b0, 6'd0));
		directed.push_back(row(KIND_QUERY, 6'd0, CLASS_IPV4, 128'd30, 128'd5, PREDICTED,
			1'b0, 6'd0));
		directed.push_back(row(KIND_LOAD, 6'd5, CLASS_IPV6, {64'd1, 64'd0}, {64'd1, W1},
			PREDICTED, 1'b0, 6'd0));
		directed.push_back(row(KIND_QUERY, 6'd0, CLASS_IPV6, {64'd1, 64'd5}, {64'd1, 64'd7},
			PREDICTED, 1'b0, 6'd0));
		directed.push_back(row(KIND_QUERY, 6'd0, CLASS_IPV6, {64'd0, W1}, {64'd1, 64'd0},
			PREDICTED, 1'b0, 6'd0));
		directed.push_back(row(KIND_LOAD, 6'd62, CLASS_NUMBER, ZERO, {64'd0, W1}, PREDICTED,
			1'b0, 6'd0));
		directed.push_back(row(KIND_QUERY, 6'd0, CLASS_NUMBER, {64'd0, W1}, {64'd0, W1},
			PREDICTED, 1'b0, 6'd0));
		directed.push_back(row(KIND_LOAD, 6'd63, CLASS_EMPTY, ZERO, ALL1, PREDICTED,
			1'b0, 6'd0));
		directed.push_back(row(KIND_QUERY, 6'd0, CLASS_IPV6, ZERO, ALL1, PREDICTED,
			1'b0, 6'd0));
		directed.push_back(row(KIND_QUERY, 6'd0, CLASS_IPV6, {64'd1, 64'd0}, {64'd1, W1},
			PREDICTED, 1'b0, 6'd0));

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed[i])
			drive_item(directed[i]);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			steady = (n >= 200 && n < 280);
			make_random_item(it);
			drive_item(it);
		end
		s_tvalid <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d loads and %0d queries; %0d results checked, %0d of them hits.",
			loads_sent, queries_sent, results_seen, hits_seen);
		$display("Output side held off for %0d cycles once; %0d mismatches.",
			HOLD_CYCLES, errors);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

@@ sim.f @@
src/rgc_pkg.sv
src/rgc_table.sv
src/rgc_range_cmp.sv
src/range_group_classifier.sv
tb/range_group_classifier_tb.sv
